@@ rtl/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// Holds the command and result beat structs, the opcode and status codes.
// No dependencies.
package deq_pkg;

    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 8;
    localparam int DEPTH_DEF = 128;

    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK_FRONT = 3'd4,
        KIND_PEEK_BACK  = 3'd5,
        KIND_CLEAR      = 3'd6,
        KIND_SIZE       = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_kind                    kind;
        logic signed [DATA_W-1:0] push_value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        t_status                  status;
        logic [COUNT_W-1:0]       count;
    } t_result;

    // Response side-band from the pointer control to the output stage
    typedef struct packed {
        logic               done;
        logic               rd_used;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_rsp_ctl;

endpackage

@@ rtl/deq_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Width and depth set by parameters; no package dependency.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/deq_ctrl.sv @@
// Head pointer and element count of the ring, with memory access generation.
// Issues at most one RAM access per accepted command; depends on deq_pkg.
module deq_ctrl #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  deq_pkg::t_cmd             i_cmd,
    output logic                      o_busy,
    output logic                      o_mem_en,
    output logic                      o_mem_we,
    output logic [AW-1:0]             o_mem_addr,
    output logic [deq_pkg::DATA_W-1:0] o_mem_wdata,
    output deq_pkg::t_rsp_ctl         o_rsp
);

    localparam int SW = AW + 2;

    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic                r_busy;
    logic                r_done;
    logic                r_rd_used, n_rd_used;
    deq_pkg::t_status    r_status, n_status;

    logic                accept;
    logic                full, empty;
    logic [AW-1:0]       head_dec, head_inc, tail_pos, back_pos;
    logic [SW-1:0]       sum, sum_m1, sum_w, sum_m1_w;
    logic [CW+7:0]       count_ext;

    assign accept = i_start && !r_busy;
    assign full   = (r_count == CW'(DEPTH));
    assign empty  = (r_count == '0);

    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    // Sum stays below twice the depth, so one subtract wraps it
    assign sum      = SW'(r_head) + SW'(r_count);
    assign sum_m1   = sum - SW'(1);
    assign sum_w    = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    assign sum_m1_w = (sum_m1 >= SW'(DEPTH)) ? sum_m1 - SW'(DEPTH) : sum_m1;
    assign tail_pos = sum_w[AW-1:0];
    assign back_pos = sum_m1_w[AW-1:0];

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_status    = deq_pkg::ST_OK;
        n_rd_used   = 1'b0;
        o_mem_en    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_head;
        o_mem_wdata = i_cmd.push_value;
        if (accept) begin
            unique case (i_cmd.kind) inside
                deq_pkg::KIND_PUSH_FRONT: begin
                    if (full) begin
                        n_status = deq_pkg::ST_FULL;
                    end else begin
                        n_head     = head_dec;
                        n_count    = r_count + CW'(1);
                        o_mem_en   = 1'b1;
                        o_mem_we   = 1'b1;
                        o_mem_addr = head_dec;
                    end
                end
                deq_pkg::KIND_PUSH_BACK: begin
                    if (full) begin
                        n_status = deq_pkg::ST_FULL;
                    end else begin
                        n_count    = r_count + CW'(1);
                        o_mem_en   = 1'b1;
                        o_mem_we   = 1'b1;
                        o_mem_addr = tail_pos;
                    end
                end
                deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_PEEK_FRONT: begin
                    if (empty) begin
                        n_status = deq_pkg::ST_EMPTY;
                    end else begin
                        n_rd_used  = 1'b1;
                        o_mem_en   = 1'b1;
                        o_mem_addr = r_head;
                        if (i_cmd.kind == deq_pkg::KIND_POP_FRONT) begin
                            n_head  = head_inc;
                            n_count = r_count - CW'(1);
                        end
                    end
                end
                deq_pkg::KIND_POP_BACK, deq_pkg::KIND_PEEK_BACK: begin
                    if (empty) begin
                        n_status = deq_pkg::ST_EMPTY;
                    end else begin
                        n_rd_used  = 1'b1;
                        o_mem_en   = 1'b1;
                        o_mem_addr = back_pos;
                        if (i_cmd.kind == deq_pkg::KIND_POP_BACK) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
                deq_pkg::KIND_CLEAR: begin
                    n_head  = '0;
                    n_count = '0;
                end
                default: begin
                    // size query: state untouched
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_busy    <= 1'b1;
            r_done    <= 1'b0;
            r_rd_used <= 1'b0;
            r_status  <= deq_pkg::ST_OK;
        end else begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_busy    <= 1'b0;
            r_done    <= accept;
            r_rd_used <= n_rd_used;
            r_status  <= n_status;
        end
    end

    // r_count already holds the post-command value while the result is shown
    assign count_ext = {8'd0, r_count};

    // Hold busy for as long as reset is asserted, from the very first cycle
    assign o_busy        = r_busy || !i_rst_n;
    assign o_rsp.done    = r_done;
    assign o_rsp.rd_used = r_rd_used;
    assign o_rsp.status  = r_status;
    assign o_rsp.count   = count_ext[deq_pkg::COUNT_W-1:0];

endmodule

@@ rtl/double_ended_queue_top.sv @@
// Top level of the double-ended queue: ring pointer control plus one ring RAM.
// Depends on deq_pkg, deq_ctrl and deq_ram.
//
//  channel   | direction | handshake            | beat
//  ----------+-----------+----------------------+-----------------------------
//  command   | in        | i_start && !o_busy   | i_cmd    (t_cmd)
//  result    | out       | o_done, one cycle    | o_result (t_result)
//
// One command is taken every cycle while o_busy is low; its result appears in the
// cycle after the accepting edge, set by the registered read of the ring RAM port.
// Pointer and count update at the accepting edge, so a following command sees
// them at once and the RAM write of a push lands before any later read.
// Reset is synchronous; o_busy stays high while reset is held and drops on
// the first edge after it lifts. Results cannot be stalled by the receiver.
module double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  deq_pkg::t_cmd    i_cmd,
    output logic             o_busy,
    output logic             o_done,
    output deq_pkg::t_result o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                       mem_en;
    logic                       mem_we;
    logic [AW-1:0]              mem_addr;
    logic [deq_pkg::DATA_W-1:0] mem_wdata;
    logic [deq_pkg::DATA_W-1:0] mem_rdata;
    deq_pkg::t_rsp_ctl          rsp;

    deq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cmd       (i_cmd),
        .o_busy      (o_busy),
        .o_mem_en    (mem_en),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .o_rsp       (rsp)
    );

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Drop stale RAM data for commands that read nothing
    assign o_done              = rsp.done;
    assign o_result.read_value = rsp.rd_used ? mem_rdata : '0;
    assign o_result.status     = rsp.status;
    assign o_result.count      = rsp.count;

endmodule

@@ rtl/deq_chk.sv @@
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg.
module deq_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input deq_pkg::t_cmd    i_cmd,
    input logic             o_busy,
    input logic             o_done,
    input deq_pkg::t_result o_result
);

    logic beat_in;
    assign beat_in = i_start && !o_busy;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat_in |=> o_done)
        else $error("command beat without a result one cycle later");

    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(beat_in))
        else $error("result beat without a command beat before it");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != deq_pkg::ST_OK) |-> (o_result.read_value == '0))
        else $error("read value not zero on an error result");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(beat_in && i_cmd.kind == deq_pkg::KIND_CLEAR))
            |-> (o_result.count == '0 && o_result.status == deq_pkg::ST_OK))
        else $error("clear left elements behind");

    a_push_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(beat_in && (i_cmd.kind == deq_pkg::KIND_PUSH_FRONT
                                     || i_cmd.kind == deq_pkg::KIND_PUSH_BACK)))
            |-> (o_result.status != deq_pkg::ST_EMPTY))
        else $error("push reported an empty queue");

endmodule

bind double_ended_queue_top deq_chk u_deq_chk (.*);

@@ test/deq_checker.sv @@
// Scoreboard for the double-ended queue: follows the command and result beats,
// keeps its own ring and counts any mismatch. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  deq_pkg::t_cmd    i_cmd,
    input  logic             i_done,
    input  deq_pkg::t_result i_result,
    output int               o_fail_count,
    output int               o_outstanding,
    output int               o_checked,
    output int               o_full_seen,
    output int               o_empty_seen
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] ring [DEPTH];
    int      front_slot;
    int      occupancy;
    t_result awaited_results [$];
    int      errors     = 0;
    int      checked    = 0;
    int      full_seen  = 0;
    int      empty_seen = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        o_checked     = 0;
        o_full_seen   = 0;
        o_empty_seen  = 0;
        front_slot    = 0;
        occupancy     = 0;
    end

    // Apply one command to the shadow ring and return the result it should give
    function automatic t_result apply_command(input t_cmd cmd);
        t_result res;
        int      slot;
        res.read_value = '0;
        res.status     = ST_OK;
        case (cmd.kind)
            KIND_PUSH_FRONT: begin
                if (occupancy >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    front_slot       = (front_slot + DEPTH - 1) % DEPTH;
                    ring[front_slot] = cmd.push_value;
                    occupancy++;
                end
            end
            KIND_PUSH_BACK: begin
                if (occupancy >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot       = (front_slot + occupancy) % DEPTH;
                    ring[slot] = cmd.push_value;
                    occupancy++;
                end
            end
            KIND_POP_FRONT, KIND_PEEK_FRONT: begin
                if (occupancy == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = ring[front_slot];
                    if (cmd.kind == KIND_POP_FRONT) begin
                        front_slot = (front_slot + 1) % DEPTH;
                        occupancy--;
                    end
                end
            end
            KIND_POP_BACK, KIND_PEEK_BACK: begin
                if (occupancy == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot           = (front_slot + occupancy - 1) % DEPTH;
                    res.read_value = ring[slot];
                    if (cmd.kind == KIND_POP_BACK) begin
                        occupancy--;
                    end
                end
            end
            KIND_CLEAR: begin
                front_slot = 0;
                occupancy  = 0;
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(occupancy);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            front_slot = 0;
            occupancy  = 0;
            awaited_results.delete();
        end else begin
            // the result beat of this edge belongs to a command taken earlier
            if (i_done) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with none pending: %0d status %0d count %0d",
                             $time, i_result.read_value, i_result.status,
                             i_result.count);
                end else begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    checked++;
                    if (want.status == ST_FULL) full_seen++;
                    if (want.status == ST_EMPTY) empty_seen++;
                    if (i_result.read_value !== want.read_value) begin
                        errors++;
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, i_result.read_value);
                    end
                    if (i_result.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_result.status);
                    end
                    if (i_result.count !== want.count) begin
                        errors++;
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, i_result.count);
                    end
                end
            end
            if (i_start && !i_busy) begin
                awaited_results = {awaited_results, apply_command(i_cmd)};
            end
        end
        o_fail_count  <= errors;
        o_outstanding <= awaited_results.size();
        o_checked     <= checked;
        o_full_seen   <= full_seen;
        o_empty_seen  <= empty_seen;
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the double-ended queue: clock, reset, command stimulus
// and verdict. Depends on deq_pkg, double_ended_queue_top and deq_checker.
`timescale 1ns / 1ps

module tb_top;
    import deq_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int PHASE_ITEMS = 500;
    localparam int FILL_LEN    = 136;
    localparam int DRAIN_LEN   = 140;
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    o_busy;
    logic    o_done;
    t_result o_result;

    int cycle_count = 0;
    int sent        = 0;
    int idle_pct    = 0;
    int fail_count;
    int outstanding;
    int checked;
    int full_seen;
    int empty_seen;

    double_ended_queue_top #(
        .DEPTH (DEPTH_DEF)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    deq_checker #(
        .DEPTH (DEPTH_DEF)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_cmd         (i_cmd),
        .i_done        (o_done),
        .i_result      (o_result),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_full_seen   (full_seen),
        .o_empty_seen  (empty_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Run stopped at cycle %0d with %0d results pending",
                     cycle_count, outstanding);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Hold the beat until the block takes it, idling first at the current rate
    task automatic send_cmd(input t_kind kind, input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start           <= 1'b1;
        i_cmd.kind        <= kind;
        i_cmd.push_value  <= value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic t_kind pick_kind(input int mode);
        int roll;
        int push_lim;
        int pop_lim;
        int peek_lim;
        int size_lim;
        roll = $urandom_range(99);
        case (mode)
            MODE_GROW:   begin push_lim = 70; pop_lim = 85; peek_lim = 94; size_lim = 98; end
            MODE_SHRINK: begin push_lim = 20; pop_lim = 75; peek_lim = 88; size_lim = 96; end
            default:     begin push_lim = 45; pop_lim = 80; peek_lim = 92; size_lim = 97; end
        endcase
        if (roll < push_lim) return $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        if (roll < pop_lim)  return $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
        if (roll < peek_lim) return $urandom_range(1) ? KIND_PEEK_BACK : KIND_PEEK_FRONT;
        if (roll < size_lim) return KIND_SIZE;
        return KIND_CLEAR;
    endfunction

    initial begin
        int phase_pct [3];
        int phase_sent;
        int run_len;
        int mode;
        phase_pct = '{0, 54, 26};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, signed extremes at the front, -1 and zero at the back, wrap of the head below zero
        send_cmd(KIND_POP_FRONT,  pick_word());
        send_cmd(KIND_POP_BACK,   pick_word());
        send_cmd(KIND_PEEK_FRONT, pick_word());
        send_cmd(KIND_PEEK_BACK,  pick_word());
        send_cmd(KIND_SIZE,       pick_word());
        send_cmd(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        send_cmd(KIND_PUSH_FRONT, 32'h8000_0000);
        send_cmd(KIND_PUSH_BACK,  32'hFFFF_FFFF);
        send_cmd(KIND_PUSH_BACK,  32'h0000_0000);
        send_cmd(KIND_PEEK_FRONT, pick_word());
        send_cmd(KIND_PEEK_BACK,  pick_word());
        send_cmd(KIND_SIZE,       pick_word());
        send_cmd(KIND_POP_FRONT,  pick_word());
        send_cmd(KIND_POP_BACK,   pick_word());
        send_cmd(KIND_POP_FRONT,  pick_word());
        send_cmd(KIND_POP_BACK,   pick_word());
        send_cmd(KIND_POP_FRONT,  pick_word());
        send_cmd(KIND_PUSH_BACK,  32'h5A5A_5A5A);
        send_cmd(KIND_CLEAR,      pick_word());
        send_cmd(KIND_PEEK_BACK,  pick_word());
        send_cmd(KIND_PUSH_FRONT, 32'hA5A5_A5A5);
        send_cmd(KIND_POP_BACK,   pick_word());
        send_cmd(KIND_CLEAR,      pick_word());

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct   = phase_pct[phase];
            phase_sent = sent;
            // fill past capacity so the full case comes up in every phase
            repeat (FILL_LEN) begin
                send_cmd($urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, pick_word());
            end
            while (sent - phase_sent < PHASE_ITEMS - DRAIN_LEN) begin
                run_len  = $urandom_range(20, 120);
                // trim the last run so the phase keeps its size
                if (run_len > PHASE_ITEMS - DRAIN_LEN - (sent - phase_sent)) begin
                    run_len = PHASE_ITEMS - DRAIN_LEN - (sent - phase_sent);
                end
                mode     = $urandom_range(MODE_MIX);
                idle_pct = ($urandom_range(3) == 0) ? 0 : phase_pct[phase];
                repeat (run_len) send_cmd(pick_kind(mode), pick_word());
            end
            idle_pct = phase_pct[phase];
            // drain past empty
            repeat (DRAIN_LEN) begin
                send_cmd($urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT, pick_word());
            end
        end
        i_start <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d commands over three idling phases; %0d results checked.",
                 sent, checked);
        $display("Full pushes seen: %0d, empty pops or peeks seen: %0d.", full_seen, empty_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_top.sv
rtl/deq_chk.sv
test/deq_checker.sv
test/tb_top.sv
